// ----- hdl/rti_pkg.sv -----
package rti_pkg;

  // Coordinate and intermediate widths
  localparam int unsigned QW = 31;  // quotient bits of t before the sign

  typedef logic signed [31:0] coord_t;  // Q16.16
  typedef logic signed [32:0] edge_t;   // exact difference of two coordinates
  typedef logic signed [29:0] norm_t;   // scaled normal component, |n| < 2^29

  localparam coord_t Q_MAX = 32'sh7FFF_FFFF;
  localparam coord_t Q_MIN = 32'sh8000_0000;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;

  typedef struct packed {
    edge_t x;
    edge_t y;
    edge_t z;
  } evec_t;

  typedef struct packed {
    norm_t x;
    norm_t y;
    norm_t z;
  } nvec_t;

  typedef struct packed {
    vec_t origin;
    vec_t dir;
  } ray_t;

  typedef enum logic [1:0] {
    OUTC_HIT      = 2'd0,
    OUTC_PARALLEL = 2'd1,
    OUTC_BEHIND   = 2'd2,
    OUTC_OUTSIDE  = 2'd3
  } outcome_e;

  typedef enum logic [2:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_ORIGIN_Z = 3'd2,
    CFG_DIR_X    = 3'd3,
    CFG_DIR_Y    = 3'd4,
    CFG_DIR_Z    = 3'd5
  } cfg_idx_e;

  // Axis left out of the 2D inside test
  typedef enum logic [1:0] {
    DROP_X = 2'd0,
    DROP_Y = 2'd1,
    DROP_Z = 2'd2
  } drop_e;

  // Normal stage to plane stage
  typedef struct packed {
    logic  valid;
    vec_t  a;
    evec_t e1;     // b - a, exact
    evec_t e2;     // c - a, exact
    evec_t ap;     // a - origin, exact
    nvec_t n;
    logic  nzero;
  } norm_out_t;

  // Data for the inside test that rides along the divider
  typedef struct packed {
    logic   nzero;
    drop_e  drop;
    edge_t  s1u;
    edge_t  s1v;
    edge_t  s2u;
    edge_t  s2v;
    coord_t au;
    coord_t av;
  } side_t;

  typedef struct packed {
    logic               valid;
    logic signed [64:0] num;
    logic signed [63:0] den;
    side_t              side;
  } plane_out_t;

  typedef struct packed {
    logic   valid;
    coord_t t;
    logic   neg;
    logic   par;
    side_t  side;
  } div_out_t;

  typedef struct packed {
    logic     hit;
    outcome_e outcome;
    coord_t   distance;
    coord_t   hx;
    coord_t   hy;
    coord_t   hz;
  } res_t;

  function automatic edge_t sub33(coord_t x, coord_t y);
    return $signed({x[31], x}) - $signed({y[31], y});
  endfunction

  // Magnitude of at least 2^31
  function automatic logic edge_big(edge_t e);
    return (e[32] != e[31]) || (e[32] && e[31] && (e[30:0] == '0));
  endfunction

  // Halve, truncating toward zero
  function automatic coord_t edge_half(edge_t e);
    logic signed [33:0] s;
    s = $signed({e[32], e}) + $signed({33'd0, e[32]});
    return s[32:1];
  endfunction

endpackage

// ----- hdl/rti_normal.sv -----
module rti_normal (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  rti_pkg::vec_t       a_i,
  input  rti_pkg::vec_t       b_i,
  input  rti_pkg::vec_t       c_i,
  input  rti_pkg::vec_t       origin_i,
  output rti_pkg::norm_out_t  norm_o
);

  typedef struct packed {
    rti_pkg::vec_t  a;
    rti_pkg::evec_t e1;
    rti_pkg::evec_t e2;
    rti_pkg::evec_t ap;
  } base_t;

  logic [4:0]         valid_q;
  base_t              base_d;
  base_t              base_q [5];
  logic               big_d, big_q;
  rti_pkg::vec_t      h1_d, h2_d, h1_q, h2_q;
  logic signed [63:0] prod_d [6];
  logic signed [63:0] prod_q [6];
  logic signed [64:0] diff;
  logic signed [64:0] diff_neg;
  logic [62:0]        mag_d [3];
  logic [62:0]        mag_q [3];
  logic [2:0]         sgn_d, sgn_q;
  logic [62:0]        orv;
  logic [5:0]         pos;
  logic [5:0]         shamt;
  logic [62:0]        shifted;
  rti_pkg::norm_t     nval [3];
  rti_pkg::nvec_t     n_d, n_q;
  logic               nzero_d, nzero_q;

  // Stage 1: edges, offset from origin and range check
  always_comb begin
    base_d.a    = a_i;
    base_d.e1.x = rti_pkg::sub33(b_i.x, a_i.x);
    base_d.e1.y = rti_pkg::sub33(b_i.y, a_i.y);
    base_d.e1.z = rti_pkg::sub33(b_i.z, a_i.z);
    base_d.e2.x = rti_pkg::sub33(c_i.x, a_i.x);
    base_d.e2.y = rti_pkg::sub33(c_i.y, a_i.y);
    base_d.e2.z = rti_pkg::sub33(c_i.z, a_i.z);
    base_d.ap.x = rti_pkg::sub33(a_i.x, origin_i.x);
    base_d.ap.y = rti_pkg::sub33(a_i.y, origin_i.y);
    base_d.ap.z = rti_pkg::sub33(a_i.z, origin_i.z);
    big_d = rti_pkg::edge_big(base_d.e1.x) || rti_pkg::edge_big(base_d.e1.y) ||
            rti_pkg::edge_big(base_d.e1.z) || rti_pkg::edge_big(base_d.e2.x) ||
            rti_pkg::edge_big(base_d.e2.y) || rti_pkg::edge_big(base_d.e2.z);
  end

  // Stage 2: halve both edges when any component is too wide
  always_comb begin
    if (big_q) begin
      h1_d.x = rti_pkg::edge_half(base_q[0].e1.x);
      h1_d.y = rti_pkg::edge_half(base_q[0].e1.y);
      h1_d.z = rti_pkg::edge_half(base_q[0].e1.z);
      h2_d.x = rti_pkg::edge_half(base_q[0].e2.x);
      h2_d.y = rti_pkg::edge_half(base_q[0].e2.y);
      h2_d.z = rti_pkg::edge_half(base_q[0].e2.z);
    end else begin
      h1_d.x = base_q[0].e1.x[31:0];
      h1_d.y = base_q[0].e1.y[31:0];
      h1_d.z = base_q[0].e1.z[31:0];
      h2_d.x = base_q[0].e2.x[31:0];
      h2_d.y = base_q[0].e2.y[31:0];
      h2_d.z = base_q[0].e2.z[31:0];
    end
  end

  // Stage 3: cross product terms
  always_comb begin
    prod_d[0] = h1_q.y * h2_q.z;
    prod_d[1] = h1_q.z * h2_q.y;
    prod_d[2] = h1_q.z * h2_q.x;
    prod_d[3] = h1_q.x * h2_q.z;
    prod_d[4] = h1_q.x * h2_q.y;
    prod_d[5] = h1_q.y * h2_q.x;
  end

  // Stage 4: differences as sign and magnitude
  always_comb begin
    diff     = '0;
    diff_neg = '0;
    for (int i = 0; i < 3; i++) begin
      diff      = $signed({prod_q[2*i][63], prod_q[2*i]}) -
                  $signed({prod_q[2*i+1][63], prod_q[2*i+1]});
      diff_neg  = -diff;
      sgn_d[i]  = diff[64];
      mag_d[i]  = diff[64] ? diff_neg[62:0] : diff[62:0];
    end
  end

  // Stage 5: scale the normal down below 2^29 with one common shift
  always_comb begin
    orv = mag_q[0] | mag_q[1] | mag_q[2];
    pos = '0;
    for (int i = 0; i < 63; i++) begin
      if (orv[i]) pos = 6'(i);
    end
    shamt   = (pos > 6'd28) ? (pos - 6'd28) : 6'd0;
    shifted = '0;
    for (int i = 0; i < 3; i++) begin
      shifted = mag_q[i] >> shamt;
      nval[i] = sgn_q[i] ? -$signed({1'b0, shifted[28:0]}) : $signed({1'b0, shifted[28:0]});
    end
    n_d.x   = nval[0];
    n_d.y   = nval[1];
    n_d.z   = nval[2];
    nzero_d = (orv == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      base_q[0] <= base_d;
      for (int i = 1; i < 5; i++) base_q[i] <= base_q[i-1];
      big_q   <= big_d;
      h1_q    <= h1_d;
      h2_q    <= h2_d;
      prod_q  <= prod_d;
      mag_q   <= mag_d;
      sgn_q   <= sgn_d;
      n_q     <= n_d;
      nzero_q <= nzero_d;
    end
  end

  assign norm_o.valid = valid_q[4];
  assign norm_o.a     = base_q[4].a;
  assign norm_o.e1    = base_q[4].e1;
  assign norm_o.e2    = base_q[4].e2;
  assign norm_o.ap    = base_q[4].ap;
  assign norm_o.n     = n_q;
  assign norm_o.nzero = nzero_q;

endmodule

// ----- hdl/rti_plane.sv -----
module rti_plane (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  rti_pkg::norm_out_t   norm_i,
  input  rti_pkg::vec_t        dir_i,
  output rti_pkg::plane_out_t  plane_o
);

  logic [1:0]         valid_q;
  logic signed [61:0] dp_d [3];
  logic signed [61:0] dp_q [3];
  logic signed [62:0] np_d [3];
  logic signed [62:0] np_q [3];
  logic [28:0]        mx, my, mz;
  rti_pkg::side_t     side_d, side_q, side2_q;
  logic signed [63:0] den_d, den_q;
  logic signed [64:0] num_d, num_q;

  function automatic logic [28:0] nabs(rti_pkg::norm_t n);
    rti_pkg::norm_t m;
    m = n[29] ? -n : n;
    return m[28:0];
  endfunction

  // Stage 1: dot product terms
  always_comb begin
    dp_d[0] = norm_i.n.x * dir_i.x;
    dp_d[1] = norm_i.n.y * dir_i.y;
    dp_d[2] = norm_i.n.z * dir_i.z;
    np_d[0] = norm_i.n.x * norm_i.ap.x;
    np_d[1] = norm_i.n.y * norm_i.ap.y;
    np_d[2] = norm_i.n.z * norm_i.ap.z;
  end

  // Stage 1: pick the projection plane, dropping the dominant normal axis
  always_comb begin
    mx = nabs(norm_i.n.x);
    my = nabs(norm_i.n.y);
    mz = nabs(norm_i.n.z);
    side_d.nzero = norm_i.nzero;
    side_d.drop  = rti_pkg::DROP_Z;
    if ((mz < mx) || (mz < my)) begin
      side_d.drop = (my >= mx) ? rti_pkg::DROP_Y : rti_pkg::DROP_X;
    end
    unique case (side_d.drop)
      rti_pkg::DROP_X: begin
        side_d.s1u = norm_i.e1.y;
        side_d.s1v = norm_i.e1.z;
        side_d.s2u = norm_i.e2.y;
        side_d.s2v = norm_i.e2.z;
        side_d.au  = norm_i.a.y;
        side_d.av  = norm_i.a.z;
      end
      rti_pkg::DROP_Y: begin
        side_d.s1u = norm_i.e1.z;
        side_d.s1v = norm_i.e1.x;
        side_d.s2u = norm_i.e2.z;
        side_d.s2v = norm_i.e2.x;
        side_d.au  = norm_i.a.z;
        side_d.av  = norm_i.a.x;
      end
      default: begin
        side_d.s1u = norm_i.e1.x;
        side_d.s1v = norm_i.e1.y;
        side_d.s2u = norm_i.e2.x;
        side_d.s2v = norm_i.e2.y;
        side_d.au  = norm_i.a.x;
        side_d.av  = norm_i.a.y;
      end
    endcase
  end

  // Stage 2: sum the terms
  always_comb begin
    den_d = $signed({{2{dp_q[0][61]}}, dp_q[0]}) + $signed({{2{dp_q[1][61]}}, dp_q[1]}) +
            $signed({{2{dp_q[2][61]}}, dp_q[2]});
    num_d = $signed({{2{np_q[0][62]}}, np_q[0]}) + $signed({{2{np_q[1][62]}}, np_q[1]}) +
            $signed({{2{np_q[2][62]}}, np_q[2]});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[0], norm_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dp_q    <= dp_d;
      np_q    <= np_d;
      side_q  <= side_d;
      side2_q <= side_q;
      den_q   <= den_d;
      num_q   <= num_d;
    end
  end

  assign plane_o.valid = valid_q[1];
  assign plane_o.num   = num_q;
  assign plane_o.den   = den_q;
  assign plane_o.side  = side2_q;

endmodule

// ----- hdl/rti_div.sv -----
module rti_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  rti_pkg::plane_out_t  plane_i,
  output rti_pkg::div_out_t    div_o
);

  localparam int unsigned QW = rti_pkg::QW;

  // Stage D0: magnitudes and sign
  logic               v0_q;
  logic [63:0]        un_d, un_q;
  logic [62:0]        ud_d, ud0_q;
  logic signed [64:0] num_abs;
  logic signed [63:0] den_abs;
  logic               neg0_q, par0_q;
  rti_pkg::side_t     side0_q;

  // Stage D1 and one stage per quotient bit
  logic               v_q    [QW+1];
  logic [63:0]        r_q    [QW+1];
  logic [QW-1:0]      q_q    [QW+1];
  logic [62:0]        ud_q   [QW+1];
  logic [14:0]        lo_q   [QW+1];
  logic               ovf_q  [QW+1];
  logic               neg_q  [QW+1];
  logic               par_q  [QW+1];
  rti_pkg::side_t     side_q [QW+1];

  // Output stage
  logic               vt_q;
  rti_pkg::coord_t    t_d, t_q;
  logic [31:0]        qext;
  logic               negt_q, part_q;
  rti_pkg::side_t     sidet_q;

  always_comb begin
    num_abs = plane_i.num[64] ? -plane_i.num : plane_i.num;
    den_abs = plane_i.den[63] ? -plane_i.den : plane_i.den;
    un_d    = num_abs[63:0];
    ud_d    = den_abs[62:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q    <= 1'b0;
      v_q[0]  <= 1'b0;
    end else if (en_i) begin
      v0_q    <= plane_i.valid;
      v_q[0]  <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      un_q      <= un_d;
      ud0_q     <= ud_d;
      neg0_q    <= (plane_i.num != '0) && (plane_i.num[64] != plane_i.den[63]);
      par0_q    <= (plane_i.den == '0);
      side0_q   <= plane_i.side;
      // Integer part must stay below 2^15
      r_q[0]    <= {15'd0, un_q[63:15]};
      ovf_q[0]  <= ({14'd0, un_q[63:15]} >= ud0_q);
      q_q[0]    <= '0;
      ud_q[0]   <= ud0_q;
      lo_q[0]   <= un_q[14:0];
      neg_q[0]  <= neg0_q;
      par_q[0]  <= par0_q;
      side_q[0] <= side0_q;
    end
  end

  // Restoring division, one quotient bit per stage
  for (genvar j = 1; j <= QW; j++) begin : g_step
    localparam int B = QW - j;
    logic        bin;
    logic [63:0] rs;
    logic        ge;
    logic [63:0] rn;
    logic [QW-1:0] qn;

    if (B >= 16) begin : g_bit
      assign bin = lo_q[j-1][B-16];
    end else begin : g_zero
      assign bin = 1'b0;
    end

    always_comb begin
      rs    = {r_q[j-1][62:0], bin};
      ge    = (rs >= {1'b0, ud_q[j-1]});
      rn    = ge ? (rs - {1'b0, ud_q[j-1]}) : rs;
      qn    = q_q[j-1];
      qn[B] = ge;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[j]    <= rn;
        q_q[j]    <= qn;
        ud_q[j]   <= ud_q[j-1];
        lo_q[j]   <= lo_q[j-1];
        ovf_q[j]  <= ovf_q[j-1];
        neg_q[j]  <= neg_q[j-1];
        par_q[j]  <= par_q[j-1];
        side_q[j] <= side_q[j-1];
      end
    end
  end

  // Sign, saturation and the zero cases
  always_comb begin
    qext = {1'b0, q_q[QW]};
    if (side_q[QW].nzero || par_q[QW]) begin
      t_d = '0;
    end else if (ovf_q[QW]) begin
      t_d = neg_q[QW] ? rti_pkg::Q_MIN : rti_pkg::Q_MAX;
    end else begin
      t_d = neg_q[QW] ? -$signed(qext) : $signed(qext);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vt_q <= 1'b0;
    end else if (en_i) begin
      vt_q <= v_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q     <= t_d;
      negt_q  <= neg_q[QW];
      part_q  <= par_q[QW];
      sidet_q <= side_q[QW];
    end
  end

  assign div_o.valid = vt_q;
  assign div_o.t     = t_q;
  assign div_o.neg   = negt_q;
  assign div_o.par   = part_q;
  assign div_o.side  = sidet_q;

endmodule

// ----- hdl/rti_inside.sv -----
module rti_inside (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  rti_pkg::div_out_t  div_i,
  input  rti_pkg::ray_t      ray_i,
  output logic               valid_o,
  output rti_pkg::res_t      res_o
);

  typedef struct packed {
    rti_pkg::coord_t t;
    logic            neg;
    logic            par;
    rti_pkg::side_t  side;
  } info_t;

  logic [6:0]         valid_q;
  info_t              info_d;
  info_t              info_q [6];
  logic signed [63:0] vt_d [3];
  logic signed [63:0] vt_q [3];
  rti_pkg::vec_t      h_d;
  rti_pkg::vec_t      h_q [5];
  rti_pkg::coord_t    hu, hv;
  rti_pkg::edge_t     mu_d, mv_d, mu_q, mv_q;
  logic signed [65:0] pr_d [6];
  logic signed [65:0] pr_q [6];
  logic signed [66:0] cr_d [3];
  logic signed [66:0] cr_q [3];
  logic signed [67:0] ar_d, c1_d, c2_d, ar_q, c1_q, c2_q;
  logic signed [67:0] ar_x, c1_x, c2_x;
  logic signed [68:0] slack;
  logic               in_tri;
  rti_pkg::res_t      res_d, res_q;

  // Saturated o + trunc(p / 2^16)
  function automatic rti_pkg::coord_t hpoint(rti_pkg::coord_t o, logic signed [63:0] p);
    logic signed [63:0] adj;
    logic signed [48:0] s;
    adj = p + (p[63] ? 64'sd65535 : 64'sd0);
    s   = $signed({{17{o[31]}}, o}) + $signed({adj[63], adj[63:16]});
    if (!s[48] && (s[47:31] != '0)) return rti_pkg::Q_MAX;
    if (s[48] && (s[47:31] != '1)) return rti_pkg::Q_MIN;
    return s[31:0];
  endfunction

  assign info_d.t    = div_i.t;
  assign info_d.neg  = div_i.neg;
  assign info_d.par  = div_i.par;
  assign info_d.side = div_i.side;

  // Stage H1: direction times t
  always_comb begin
    vt_d[0] = ray_i.dir.x * div_i.t;
    vt_d[1] = ray_i.dir.y * div_i.t;
    vt_d[2] = ray_i.dir.z * div_i.t;
  end

  // Stage H2: hit point, zero when there is no plane hit
  always_comb begin
    if (info_q[0].side.nzero || info_q[0].par) begin
      h_d = '0;
    end else begin
      h_d.x = hpoint(ray_i.origin.x, vt_q[0]);
      h_d.y = hpoint(ray_i.origin.y, vt_q[1]);
      h_d.z = hpoint(ray_i.origin.z, vt_q[2]);
    end
  end

  // Stage I1: project the hit point relative to vertex a
  always_comb begin
    unique case (info_q[1].side.drop)
      rti_pkg::DROP_X: begin
        hu = h_q[0].y;
        hv = h_q[0].z;
      end
      rti_pkg::DROP_Y: begin
        hu = h_q[0].z;
        hv = h_q[0].x;
      end
      default: begin
        hu = h_q[0].x;
        hv = h_q[0].y;
      end
    endcase
    mu_d = rti_pkg::sub33(hu, info_q[1].side.au);
    mv_d = rti_pkg::sub33(hv, info_q[1].side.av);
  end

  // Stage I2: 2D cross product terms
  always_comb begin
    pr_d[0] = info_q[2].side.s1u * info_q[2].side.s2v;
    pr_d[1] = info_q[2].side.s1v * info_q[2].side.s2u;
    pr_d[2] = mu_q * info_q[2].side.s2v;
    pr_d[3] = mv_q * info_q[2].side.s2u;
    pr_d[4] = info_q[2].side.s1u * mv_q;
    pr_d[5] = info_q[2].side.s1v * mu_q;
  end

  // Stage I3: area and the two sub-areas
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cr_d[i] = $signed({pr_q[2*i][65], pr_q[2*i]}) - $signed({pr_q[2*i+1][65], pr_q[2*i+1]});
    end
  end

  // Stage I4: flip signs so the area is positive
  always_comb begin
    ar_x = $signed({cr_q[0][66], cr_q[0]});
    c1_x = $signed({cr_q[1][66], cr_q[1]});
    c2_x = $signed({cr_q[2][66], cr_q[2]});
    if (cr_q[0][66]) begin
      ar_d = -ar_x;
      c1_d = -c1_x;
      c2_d = -c2_x;
    end else begin
      ar_d = ar_x;
      c1_d = c1_x;
      c2_d = c2_x;
    end
  end

  // Stage I5: inside test and outcome
  always_comb begin
    slack  = $signed({c1_q[67], c1_q}) + $signed({c2_q[67], c2_q}) - $signed({ar_q[67], ar_q});
    in_tri = (ar_q != '0) && !c1_q[67] && !c2_q[67] && slack[68];
    priority if (info_q[5].side.nzero) begin
      res_d.outcome = rti_pkg::OUTC_OUTSIDE;
    end else if (info_q[5].par) begin
      res_d.outcome = rti_pkg::OUTC_PARALLEL;
    end else if (info_q[5].neg) begin
      res_d.outcome = rti_pkg::OUTC_BEHIND;
    end else if (in_tri) begin
      res_d.outcome = rti_pkg::OUTC_HIT;
    end else begin
      res_d.outcome = rti_pkg::OUTC_OUTSIDE;
    end
    res_d.hit      = (res_d.outcome == rti_pkg::OUTC_HIT);
    res_d.distance = info_q[5].t;
    res_d.hx       = h_q[4].x;
    res_d.hy       = h_q[4].y;
    res_d.hz       = h_q[4].z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[5:0], div_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      info_q[0] <= info_d;
      for (int i = 1; i < 6; i++) info_q[i] <= info_q[i-1];
      vt_q <= vt_d;
      h_q[0] <= h_d;
      for (int i = 1; i < 5; i++) h_q[i] <= h_q[i-1];
      mu_q  <= mu_d;
      mv_q  <= mv_d;
      pr_q  <= pr_d;
      cr_q  <= cr_d;
      ar_q  <= ar_d;
      c1_q  <= c1_d;
      c2_q  <= c2_d;
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q[6];
  assign res_o   = res_q;

endmodule

// ----- hdl/ray_triangle_intersect.sv -----
// Ray / triangle intersection, fully pipelined.
// Throughput: one triangle per cycle while in_stall_o is low; the 31-stage
// quotient pipeline for t sets the depth. A two-entry output buffer holds
// results under stall. Reset clears all valid bits and the buffer and loads
// the ray registers with origin (0, 0, 0) and direction (0, 0, 1.0).
module ray_triangle_intersect (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Ray configuration
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_wdata_i,
  // Triangle items
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [31:0]  ax_i,
  input  logic [31:0]  ay_i,
  input  logic [31:0]  az_i,
  input  logic [31:0]  bx_i,
  input  logic [31:0]  by_i,
  input  logic [31:0]  bz_i,
  input  logic [31:0]  cx_i,
  input  logic [31:0]  cy_i,
  input  logic [31:0]  cz_i,
  // Result items
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic         hit_o,
  output logic [1:0]   outcome_o,
  output logic [31:0]  distance_o,
  output logic [31:0]  hit_x_o,
  output logic [31:0]  hit_y_o,
  output logic [31:0]  hit_z_o
);

  rti_pkg::ray_t       ray_d, ray_q;
  rti_pkg::vec_t       a_vec, b_vec, c_vec;
  rti_pkg::norm_out_t  norm;
  rti_pkg::plane_out_t plane;
  rti_pkg::div_out_t   divr;
  logic                res_valid;
  rti_pkg::res_t       res;
  logic                en;
  logic                push, pop;
  logic [1:0]          cnt_d, cnt_q;
  rti_pkg::res_t       head_d, head_q, spare_d, spare_q;

  // Ray registers
  always_comb begin
    ray_d = ray_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rti_pkg::CFG_ORIGIN_X: ray_d.origin.x = cfg_wdata_i;
        rti_pkg::CFG_ORIGIN_Y: ray_d.origin.y = cfg_wdata_i;
        rti_pkg::CFG_ORIGIN_Z: ray_d.origin.z = cfg_wdata_i;
        rti_pkg::CFG_DIR_X:    ray_d.dir.x    = cfg_wdata_i;
        rti_pkg::CFG_DIR_Y:    ray_d.dir.y    = cfg_wdata_i;
        rti_pkg::CFG_DIR_Z:    ray_d.dir.z    = cfg_wdata_i;
        default:               ray_d          = ray_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ray_q.origin <= '0;
      ray_q.dir.x  <= '0;
      ray_q.dir.y  <= '0;
      ray_q.dir.z  <= 32'sd65536;
    end else begin
      ray_q <= ray_d;
    end
  end

  // Pipeline advances while the output buffer has room
  assign en         = (cnt_q != 2'd2);
  assign in_stall_o = !en;

  assign a_vec = {ax_i, ay_i, az_i};
  assign b_vec = {bx_i, by_i, bz_i};
  assign c_vec = {cx_i, cy_i, cz_i};

  rti_normal u_normal (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .a_i      (a_vec),
    .b_i      (b_vec),
    .c_i      (c_vec),
    .origin_i (ray_q.origin),
    .norm_o   (norm)
  );

  rti_plane u_plane (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .norm_i  (norm),
    .dir_i   (ray_q.dir),
    .plane_o (plane)
  );

  rti_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .plane_i (plane),
    .div_o   (divr)
  );

  rti_inside u_inside (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .div_i   (divr),
    .ray_i   (ray_q),
    .valid_o (res_valid),
    .res_o   (res)
  );

  // Two-entry output buffer
  assign push = en && res_valid;
  assign pop  = out_valid_o && !out_stall_i;

  always_comb begin
    cnt_d   = cnt_q;
    head_d  = head_q;
    spare_d = spare_q;
    unique case (cnt_q)
      2'd0: begin
        if (push) begin
          head_d = res;
          cnt_d  = 2'd1;
        end
      end
      2'd1: begin
        if (push && pop) begin
          head_d = res;
        end else if (push) begin
          spare_d = res;
          cnt_d   = 2'd2;
        end else if (pop) begin
          cnt_d = 2'd0;
        end
      end
      default: begin
        if (pop) begin
          head_d = spare_q;
          cnt_d  = 2'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q  <= head_d;
    spare_q <= spare_d;
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign hit_o       = head_q.hit;
  assign outcome_o   = head_q.outcome;
  assign distance_o  = head_q.distance;
  assign hit_x_o     = head_q.hx;
  assign hit_y_o     = head_q.hy;
  assign hit_z_o     = head_q.hz;

  // Checks
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output buffer count out of range");

  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  a_hit_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && hit_o) |-> (outcome_o == rti_pkg::OUTC_HIT))
    else $error("hit flag disagrees with outcome");

  a_parallel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (outcome_o == rti_pkg::OUTC_PARALLEL)) |->
      ((distance_o == '0) && (hit_x_o == '0) && (hit_y_o == '0) && (hit_z_o == '0)))
    else $error("parallel ray reports a nonzero distance or point");

endmodule

// ----- tb/ray_triangle_checker.sv -----
`timescale 1ns / 100ps

module ray_triangle_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [31:0] ax_i,
  input  logic [31:0] ay_i,
  input  logic [31:0] az_i,
  input  logic [31:0] bx_i,
  input  logic [31:0] by_i,
  input  logic [31:0] bz_i,
  input  logic [31:0] cx_i,
  input  logic [31:0] cy_i,
  input  logic [31:0] cz_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        hit_i,
  input  logic [1:0]  outcome_i,
  input  logic [31:0] distance_i,
  input  logic [31:0] hit_x_i,
  input  logic [31:0] hit_y_i,
  input  logic [31:0] hit_z_i,
  output int          mismatches_o,
  output int          awaited_o,
  output int          hits_seen_o
);

  rti_pkg::vec_t ray_origin;
  rti_pkg::vec_t ray_dir;
  rti_pkg::res_t awaited_results[$];

  function automatic longint mag64(longint x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic logic signed [127:0] cross_2d(longint x1, longint y1, longint x2,
                                                    longint y2);
    logic signed [127:0] w1, w2, w3, w4;
    w1 = x1;
    w2 = y1;
    w3 = x2;
    w4 = y2;
    return w1 * w4 - w2 * w3;
  endfunction

  function automatic longint sat_q16(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Work out the result of one triangle against the current ray
  function automatic rti_pkg::res_t intersect_triangle(rti_pkg::vec_t ta, rti_pkg::vec_t tb,
                                                       rti_pkg::vec_t tc, rti_pkg::vec_t org,
                                                       rti_pkg::vec_t dir);
    longint a[3], b[3], c[3], p[3], v[3], e1[3], e2[3], n[3], h[3];
    longint num, den, t, qi, rem, frac, un, ud;
    logic big, neg;
    int drop, i0, i1;
    logic signed [127:0] ar, c1, c2;
    rti_pkg::outcome_e oc;
    rti_pkg::res_t r;
    a = '{ta.x, ta.y, ta.z};
    b = '{tb.x, tb.y, tb.z};
    c = '{tc.x, tc.y, tc.z};
    p = '{org.x, org.y, org.z};
    v = '{dir.x, dir.y, dir.z};
    h = '{0, 0, 0};
    num = 0;
    den = 0;
    t = 0;
    big = 1'b0;
    for (int i = 0; i < 3; i++) begin
      e1[i] = b[i] - a[i];
      e2[i] = c[i] - a[i];
      if (mag64(e1[i]) >= 64'sh8000_0000 || mag64(e2[i]) >= 64'sh8000_0000) big = 1'b1;
    end
    // Halve oversized edges so the cross product stays in 64 bits
    if (big) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] = e1[i] / 2;
        e2[i] = e2[i] / 2;
      end
    end
    n[0] = e1[1] * e2[2] - e1[2] * e2[1];
    n[1] = e1[2] * e2[0] - e1[0] * e2[2];
    n[2] = e1[0] * e2[1] - e1[1] * e2[0];
    while (mag64(n[0]) >= 64'sh2000_0000 || mag64(n[1]) >= 64'sh2000_0000 ||
           mag64(n[2]) >= 64'sh2000_0000) begin
      for (int i = 0; i < 3; i++) n[i] = n[i] / 2;
    end

    if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
      oc = rti_pkg::OUTC_OUTSIDE;
    end else begin
      for (int i = 0; i < 3; i++) begin
        den += n[i] * v[i];
        num += n[i] * (a[i] - p[i]);
      end
      if (den == 0) begin
        oc = rti_pkg::OUTC_PARALLEL;
      end else begin
        neg = (num != 0) && ((num < 0) != (den < 0));
        un = mag64(num);
        ud = mag64(den);
        qi = un / ud;
        rem = un % ud;
        if (qi >= 32768) begin
          t = neg ? -64'sd2147483648 : 64'sd2147483647;
        end else begin
          // Long division for the 16 fraction bits
          frac = 0;
          for (int i = 0; i < 16; i++) begin
            rem = rem * 2;
            frac = frac * 2;
            if (rem >= ud) begin
              rem -= ud;
              frac += 1;
            end
          end
          t = qi * 65536 + frac;
          if (neg) t = -t;
        end
        for (int i = 0; i < 3; i++) h[i] = sat_q16(p[i] + (v[i] * t) / 65536);
        if (neg) begin
          oc = rti_pkg::OUTC_BEHIND;
        end else begin
          drop = 2;
          if (mag64(n[2]) < mag64(n[0]) || mag64(n[2]) < mag64(n[1]))
            drop = (mag64(n[1]) >= mag64(n[0])) ? 1 : 0;
          i0 = (drop + 1) % 3;
          i1 = (drop + 2) % 3;
          ar = cross_2d(b[i0] - a[i0], b[i1] - a[i1], c[i0] - a[i0], c[i1] - a[i1]);
          c1 = cross_2d(h[i0] - a[i0], h[i1] - a[i1], c[i0] - a[i0], c[i1] - a[i1]);
          c2 = cross_2d(b[i0] - a[i0], b[i1] - a[i1], h[i0] - a[i0], h[i1] - a[i1]);
          oc = rti_pkg::OUTC_OUTSIDE;
          if (ar != 0) begin
            if (ar < 0) begin
              ar = -ar;
              c1 = -c1;
              c2 = -c2;
            end
            if (c1 >= 0 && c2 >= 0 && (c1 + c2 - ar) < 0) oc = rti_pkg::OUTC_HIT;
          end
        end
      end
    end
    r.hit      = (oc == rti_pkg::OUTC_HIT);
    r.outcome  = oc;
    r.distance = t[31:0];
    r.hx       = h[0][31:0];
    r.hy       = h[1][31:0];
    r.hz       = h[2][31:0];
    return r;
  endfunction

  assign awaited_o = awaited_results.size();

  // Track the ray, queue predictions and compare results
  always @(posedge clk_i or negedge rst_ni) begin
    rti_pkg::res_t want, got;
    if (!rst_ni) begin
      ray_origin <= '0;
      ray_dir    <= {32'sd0, 32'sd0, 32'sd65536};
      awaited_results.delete();
      mismatches_o <= 0;
      hits_seen_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (rti_pkg::cfg_idx_e'(cfg_idx_i))
          rti_pkg::CFG_ORIGIN_X: ray_origin.x <= cfg_wdata_i;
          rti_pkg::CFG_ORIGIN_Y: ray_origin.y <= cfg_wdata_i;
          rti_pkg::CFG_ORIGIN_Z: ray_origin.z <= cfg_wdata_i;
          rti_pkg::CFG_DIR_X:    ray_dir.x    <= cfg_wdata_i;
          rti_pkg::CFG_DIR_Y:    ray_dir.y    <= cfg_wdata_i;
          rti_pkg::CFG_DIR_Z:    ray_dir.z    <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        awaited_results.push_back(intersect_triangle({ax_i, ay_i, az_i}, {bx_i, by_i, bz_i},
                                                     {cx_i, cy_i, cz_i}, ray_origin,
                                                     ray_dir));
      if (out_valid_i && !out_stall_i) begin
        got.hit      = hit_i;
        got.outcome  = rti_pkg::outcome_e'(outcome_i);
        got.distance = distance_i;
        got.hx       = hit_x_i;
        got.hy       = hit_y_i;
        got.hz       = hit_z_i;
        if (awaited_results.size() == 0) begin
          mismatches_o <= mismatches_o + 1;
          if (mismatches_o < 10) $display("unexpected result item: %p", got);
        end else begin
          want = awaited_results.pop_front();
          if (want.hit) hits_seen_o <= hits_seen_o + 1;
          if (want !== got) begin
            mismatches_o <= mismatches_o + 1;
            if (mismatches_o < 10) begin
              $display("mismatch: hit %0b/%0b outcome %0d/%0d t %h/%h", want.hit, got.hit,
                       want.outcome, got.outcome, want.distance, got.distance);
              $display("  point exp %h %h %h got %h %h %h", want.hx, want.hy, want.hz,
                       got.hx, got.hy, got.hz);
            end
          end
        end
      end
    end
  end

endmodule

// ----- tb/tb_ray_triangle_intersect.sv -----
`timescale 1ns / 100ps

module tb_ray_triangle_intersect;

  localparam int CycleLimit = 400000;
  localparam int OneUnit    = 65536;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] ax_i, ay_i, az_i, bx_i, by_i, bz_i, cx_i, cy_i, cz_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        hit_o;
  logic [1:0]  outcome_o;
  logic [31:0] distance_o, hit_x_o, hit_y_o, hit_z_o;

  int  mismatches;
  int  awaited;
  int  hits_seen;
  int  tx_idle_pct;
  int  rx_idle_pct;
  int  cycles;
  int  items_sent;
  logic long_hold_req;
  logic long_hold_done;
  int   hold_left;
  rti_pkg::vec_t cur_origin;
  rti_pkg::vec_t cur_dir;

  ray_triangle_intersect u_top (.*);

  ray_triangle_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_i(in_stall_o),
    .ax_i, .ay_i, .az_i, .bx_i, .by_i, .bz_i, .cx_i, .cy_i, .cz_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .hit_i(hit_o), .outcome_i(outcome_o), .distance_i(distance_o),
    .hit_x_i(hit_x_o), .hit_y_i(hit_y_o), .hit_z_i(hit_z_o),
    .mismatches_o(mismatches), .awaited_o(awaited), .hits_seen_o(hits_seen)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Stall the result side at random, with one long hold-off on request
  always @(posedge clk_i) begin
    if (long_hold_req && !long_hold_done) begin
      long_hold_done <= 1'b1;
      hold_left      <= 400;
      out_stall_i    <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Give up on a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic rti_pkg::vec_t mk_vec(longint x, longint y, longint z);
    rti_pkg::vec_t r;
    r.x = x[31:0];
    r.y = y[31:0];
    r.z = z[31:0];
    return r;
  endfunction

  function automatic rti_pkg::vec_t rand_vec(int span);
    return mk_vec($signed($urandom_range(2 * span)) - span,
                  $signed($urandom_range(2 * span)) - span,
                  $signed($urandom_range(2 * span)) - span);
  endfunction

  // Offer one triangle, idling first at the sender's rate
  task automatic send_triangle(rti_pkg::vec_t ta, rti_pkg::vec_t tb, rti_pkg::vec_t tc);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {ax_i, ay_i, az_i} <= ta;
    {bx_i, by_i, bz_i} <= tb;
    {cx_i, cy_i, cz_i} <= tc;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  // Drop valid and let every expected result come back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (awaited != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // Load all six ray registers while the block is idle
  task automatic load_ray(rti_pkg::vec_t org, rti_pkg::vec_t dir);
    logic [31:0] vals[6];
    drain();
    vals = '{org.x, org.y, org.z, dir.x, dir.y, dir.z};
    for (int i = 0; i < 6; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= i[2:0];
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i   <= 1'b0;
    cur_origin = org;
    cur_dir    = dir;
  endtask

  // Mostly triangles placed around a point on the ray, plus noise
  task automatic send_random_triangle();
    int   pick;
    longint t0, hx, hy, hz;
    rti_pkg::vec_t ta, tb, tc;
    pick = $urandom_range(99);
    if (pick < 60) begin
      t0 = $signed($urandom_range(5 * OneUnit)) - OneUnit;
      hx = longint'(cur_origin.x) + (longint'(cur_dir.x) * t0) / OneUnit;
      hy = longint'(cur_origin.y) + (longint'(cur_dir.y) * t0) / OneUnit;
      hz = longint'(cur_origin.z) + (longint'(cur_dir.z) * t0) / OneUnit;
      ta = mk_vec(hx + $signed($urandom_range(1 << 19)) - (1 << 18),
                  hy + $signed($urandom_range(1 << 19)) - (1 << 18),
                  hz + $signed($urandom_range(1 << 19)) - (1 << 18));
      tb = mk_vec(hx + $signed($urandom_range(1 << 19)) - (1 << 18),
                  hy + $signed($urandom_range(1 << 19)) - (1 << 18),
                  hz + $signed($urandom_range(1 << 19)) - (1 << 18));
      tc = mk_vec(hx + $signed($urandom_range(1 << 19)) - (1 << 18),
                  hy + $signed($urandom_range(1 << 19)) - (1 << 18),
                  hz + $signed($urandom_range(1 << 19)) - (1 << 18));
    end else if (pick < 80) begin
      ta = {$urandom, $urandom, $urandom};
      tb = {$urandom, $urandom, $urandom};
      tc = {$urandom, $urandom, $urandom};
    end else if (pick < 88) begin
      // collinear or repeated vertices
      ta = rand_vec(1 << 20);
      tb = rand_vec(1 << 20);
      tc = ($urandom_range(1)) ? ta : mk_vec(2 * longint'(tb.x) - ta.x,
                                             2 * longint'(tb.y) - ta.y,
                                             2 * longint'(tb.z) - ta.z);
    end else begin
      ta = rand_vec(1 << 22);
      tb = rand_vec(1 << 22);
      tc = rand_vec(1 << 22);
    end
    send_triangle(ta, tb, tc);
  endtask

  initial begin
    rst_ni         = 1'b0;
    clk_i          = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = rti_pkg::CFG_ORIGIN_X;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    {ax_i, ay_i, az_i, bx_i, by_i, bz_i, cx_i, cy_i, cz_i} = '0;
    out_stall_i    = 1'b0;
    long_hold_req  = 1'b0;
    long_hold_done = 1'b0;
    hold_left      = 0;
    cycles         = 0;
    items_sent     = 0;
    tx_idle_pct    = 12;
    rx_idle_pct    = 83;
    cur_origin     = '0;
    cur_dir        = mk_vec(0, 0, OneUnit);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed cases against the reset ray along +z
    send_triangle(mk_vec(-OneUnit, -OneUnit, 5 * OneUnit), mk_vec(OneUnit, -OneUnit,
                  5 * OneUnit), mk_vec(0, OneUnit, 5 * OneUnit));
    send_triangle(mk_vec(-OneUnit, -OneUnit, -5 * OneUnit), mk_vec(OneUnit, -OneUnit,
                  -5 * OneUnit), mk_vec(0, OneUnit, -5 * OneUnit));
    send_triangle(mk_vec(OneUnit, 0, 0), mk_vec(OneUnit, OneUnit, 0),
                  mk_vec(OneUnit, 0, OneUnit));
    send_triangle(mk_vec(-OneUnit, -OneUnit, 0), mk_vec(OneUnit, -OneUnit, 0),
                  mk_vec(0, OneUnit, 0));
    send_triangle(mk_vec(10 * OneUnit, 10 * OneUnit, 5 * OneUnit),
                  mk_vec(12 * OneUnit, 10 * OneUnit, 5 * OneUnit),
                  mk_vec(11 * OneUnit, 12 * OneUnit, 5 * OneUnit));
    send_triangle('0, '0, '0);
    send_triangle(mk_vec(0, 0, OneUnit), mk_vec(OneUnit, OneUnit, 2 * OneUnit),
                  mk_vec(2 * OneUnit, 2 * OneUnit, 3 * OneUnit));
    send_triangle({3{rti_pkg::Q_MAX}}, {3{rti_pkg::Q_MAX}}, {3{rti_pkg::Q_MAX}});
    send_triangle({3{rti_pkg::Q_MIN}}, {3{rti_pkg::Q_MIN}}, {3{rti_pkg::Q_MIN}});
    send_triangle({rti_pkg::Q_MIN, rti_pkg::Q_MIN, rti_pkg::Q_MAX},
                  {rti_pkg::Q_MAX, rti_pkg::Q_MIN, rti_pkg::Q_MAX},
                  {rti_pkg::Q_MIN, rti_pkg::Q_MAX, rti_pkg::Q_MAX});
    send_triangle({rti_pkg::Q_MIN, rti_pkg::Q_MAX, rti_pkg::Q_MIN},
                  {rti_pkg::Q_MAX, rti_pkg::Q_MIN, rti_pkg::Q_MAX},
                  {rti_pkg::Q_MAX, rti_pkg::Q_MAX, rti_pkg::Q_MIN});
    send_triangle(mk_vec(-OneUnit, -OneUnit, rti_pkg::Q_MAX),
                  mk_vec(OneUnit, -OneUnit, rti_pkg::Q_MAX),
                  mk_vec(0, OneUnit, rti_pkg::Q_MAX));
    // large triangle in a plane barely tilted from z = 1.0
    send_triangle(mk_vec(0, 0, OneUnit), mk_vec(rti_pkg::Q_MAX, 0, OneUnit + 1),
                  mk_vec(0, rti_pkg::Q_MAX, OneUnit));

    // Extreme ray, then a zero direction
    load_ray({rti_pkg::Q_MAX, rti_pkg::Q_MIN, rti_pkg::Q_MAX},
             {rti_pkg::Q_MIN, rti_pkg::Q_MAX, rti_pkg::Q_MIN});
    for (int i = 0; i < 5; i++) send_random_triangle();
    send_triangle({3{rti_pkg::Q_MIN}}, {rti_pkg::Q_MAX, rti_pkg::Q_MIN, rti_pkg::Q_MIN},
                  {rti_pkg::Q_MIN, rti_pkg::Q_MAX, rti_pkg::Q_MAX});
    load_ray(mk_vec(OneUnit, -OneUnit, 0), '0);
    for (int i = 0; i < 4; i++) send_random_triangle();

    // Random phases under three idling patterns
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 83 : 0;
      rx_idle_pct = (ph == 0) ? 83 : (ph == 1) ? 12 : 0;
      for (int k = 0; k < 4; k++) begin
        load_ray(rand_vec(1 << 20), rand_vec(1 << 17));
        if (ph == 2 && k == 0) long_hold_req = 1'b1;
        for (int i = 0; i < 108; i++) send_random_triangle();
      end
    end

    drain();
    $display("sent %0d triangles over 15 ray settings, %0d of them hits",
             items_sent, hits_seen);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatching result items", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
